@@ rtl/complex_dot_product_top_macros.svh @@
// assertion macros for the complex dot product block
`ifndef COMPLEX_DOT_PRODUCT_TOP_MACROS_SVH
`define COMPLEX_DOT_PRODUCT_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CDP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define CDP_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define CDP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CDP_ASSERT_NEXT(label, clk, ante, cons)
`endif

`endif

@@ rtl/cdp_pkg.sv @@
// shared constants and types for the complex dot product block
package cdp_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF    = 48;
    localparam int FIFO_DEPTH       = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

@@ rtl/cdp_if.sv @@
// stream interfaces for sample pairs and dot product results
interface cdp_in_if #(
    parameter int SAMPLE_WIDTH = cdp_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] a_real;
    logic signed [SAMPLE_WIDTH-1:0] a_imag;
    logic signed [SAMPLE_WIDTH-1:0] b_real;
    logic signed [SAMPLE_WIDTH-1:0] b_imag;
    logic                           last_item;

    modport source (
        output valid, a_real, a_imag, b_real, b_imag, last_item,
        input  ready
    );
    modport sink (
        input  valid, a_real, a_imag, b_real, b_imag, last_item,
        output ready
    );
endinterface

interface cdp_out_if #(
    parameter int ACC_WIDTH = cdp_pkg::ACC_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [ACC_WIDTH-1:0] dot_real;
    logic signed [ACC_WIDTH-1:0] dot_imag;
    logic                        overflow;

    modport source (
        output valid, dot_real, dot_imag, overflow,
        input  ready
    );
    modport sink (
        input  valid, dot_real, dot_imag, overflow,
        output ready
    );
endinterface

@@ rtl/complex_dot_product_top.sv @@
// top level of the complex conjugate dot product accumulator
// Accumulates conj(a)*b over a vector of complex Q1.15 sample pairs into two saturating
// Q18.30 accumulators and returns both sums plus a sticky overflow flag on the item
// marked last, then starts the next vector from zero. One sample pair is taken every
// clock cycle in steady state: the front end is a two-stage pipeline (four products,
// then the two conjugate terms), a four-entry queue decouples it from the back end, and
// the back end does one add-and-clamp per cycle, which is the only loop in the design.
// A result reaches the output register after its last pair passes the product and term registers
// and the queue; the input only stops when the queue fills behind an unread result.
`include "complex_dot_product_top_macros.svh"

module complex_dot_product_top #(
    parameter int SAMPLE_WIDTH = cdp_pkg::SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = cdp_pkg::ACC_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdp_in_if.sink    i_in,
    cdp_out_if.source o_out
);
    import cdp_pkg::*;

    localparam int TW = 2 * SAMPLE_WIDTH + 1;
    localparam int QW = 2 * TW + 1;

    t_fifo_status  w_fifo_stat;
    logic          w_push;
    logic [QW-1:0] w_push_data;
    logic          w_pop;
    logic [QW-1:0] w_pop_data;

    cdp_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TERM_WIDTH   (TW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_fifo_stat (w_fifo_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    cdp_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_fifo_stat)
    );

    cdp_back #(
        .TERM_WIDTH (TW),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_stat (w_fifo_stat),
        .i_pop_data  (w_pop_data),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

    `CDP_ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, w_fifo_stat.full, !w_push)
    `CDP_ASSERT_IMPL(a_no_pop_when_empty, i_clk, i_rst_n, w_fifo_stat.empty, !w_pop)
    `CDP_ASSERT_NEXT(a_reset_clears_result, i_clk, !i_rst_n, !o_out.valid && w_fifo_stat.empty)

endmodule

@@ rtl/cdp_front.sv @@
// front end: accepts sample pairs, forms products and conjugate terms
module cdp_front #(
    parameter int SAMPLE_WIDTH = cdp_pkg::SAMPLE_WIDTH_DEF,
    parameter int TERM_WIDTH   = 2 * cdp_pkg::SAMPLE_WIDTH_DEF + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    cdp_in_if.sink                    i_in,
    input  cdp_pkg::t_fifo_status     i_fifo_stat,
    output logic                      o_push,
    output logic [2*TERM_WIDTH:0]     o_push_data
);
    import cdp_pkg::*;

    localparam int PW = 2 * SAMPLE_WIDTH;

    logic                         r_s1_valid;
    logic                         r_s1_last;
    logic signed [PW-1:0]         r_p_rr;
    logic signed [PW-1:0]         r_p_ii;
    logic signed [PW-1:0]         r_p_ri;
    logic signed [PW-1:0]         r_p_ir;
    logic                         r_s2_valid;
    logic                         r_s2_last;
    logic signed [TERM_WIDTH-1:0] r_t_re;
    logic signed [TERM_WIDTH-1:0] r_t_im;
    logic                         w_s1_adv;
    logic                         w_s2_adv;

    assign w_s2_adv    = !r_s2_valid || !i_fifo_stat.full;
    assign w_s1_adv    = !r_s1_valid || w_s2_adv;
    assign i_in.ready  = w_s1_adv;
    assign o_push      = r_s2_valid && !i_fifo_stat.full;
    assign o_push_data = {r_s2_last, r_t_re, r_t_im};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (w_s1_adv && i_in.valid) begin
            r_p_rr    <= PW'(i_in.a_real) * PW'(i_in.b_real);
            r_p_ii    <= PW'(i_in.a_imag) * PW'(i_in.b_imag);
            r_p_ri    <= PW'(i_in.a_real) * PW'(i_in.b_imag);
            r_p_ir    <= PW'(i_in.a_imag) * PW'(i_in.b_real);
            r_s1_last <= i_in.last_item;
        end
    end

    // conj(a)*b terms
    always_ff @(posedge i_clk) begin
        if (w_s2_adv && r_s1_valid) begin
            r_t_re    <= TERM_WIDTH'(r_p_rr) + TERM_WIDTH'(r_p_ii);
            r_t_im    <= TERM_WIDTH'(r_p_ri) - TERM_WIDTH'(r_p_ir);
            r_s2_last <= r_s1_last;
        end
    end

endmodule

@@ rtl/cdp_fifo.sv @@
// short queue between front end and accumulator
module cdp_fifo #(
    parameter int WIDTH = 4 * cdp_pkg::SAMPLE_WIDTH_DEF + 3,
    parameter int DEPTH = cdp_pkg::FIFO_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_push_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_pop_data,
    output cdp_pkg::t_fifo_status o_stat
);
    import cdp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ rtl/cdp_back.sv @@
// back end: saturating accumulators and result register
module cdp_back #(
    parameter int TERM_WIDTH = 2 * cdp_pkg::SAMPLE_WIDTH_DEF + 1,
    parameter int ACC_WIDTH  = cdp_pkg::ACC_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cdp_pkg::t_fifo_status i_fifo_stat,
    input  logic [2*TERM_WIDTH:0] i_pop_data,
    output logic                  o_pop,
    cdp_out_if.source             o_out
);
    import cdp_pkg::*;

    localparam int EW = ((ACC_WIDTH > TERM_WIDTH) ? ACC_WIDTH : TERM_WIDTH) + 1;

    logic signed [ACC_WIDTH-1:0]  r_sum_re;
    logic signed [ACC_WIDTH-1:0]  r_sum_im;
    logic                         r_sat;
    logic                         r_out_valid;
    logic signed [ACC_WIDTH-1:0]  r_dot_re;
    logic signed [ACC_WIDTH-1:0]  r_dot_im;
    logic                         r_ovf;
    logic                         w_last;
    logic signed [TERM_WIDTH-1:0] w_term_re;
    logic signed [TERM_WIDTH-1:0] w_term_im;
    logic signed [EW-1:0]         w_wide_re;
    logic signed [EW-1:0]         w_wide_im;
    logic                         w_ovf_re;
    logic                         w_ovf_im;
    logic signed [ACC_WIDTH-1:0]  n_sum_re;
    logic signed [ACC_WIDTH-1:0]  n_sum_im;
    logic                         n_sat;

    function automatic logic [ACC_WIDTH-1:0] clamp(input logic [EW-1:0] v, input logic ovf);
        logic [ACC_WIDTH-1:0] res;
        if (!ovf) begin
            res = v[ACC_WIDTH-1:0];
        end else if (v[EW-1]) begin
            res = {1'b1, {(ACC_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    assign w_last    = i_pop_data[2*TERM_WIDTH];
    assign w_term_re = i_pop_data[2*TERM_WIDTH-1:TERM_WIDTH];
    assign w_term_im = i_pop_data[TERM_WIDTH-1:0];

    assign o_pop = !i_fifo_stat.empty && (!w_last || !r_out_valid || o_out.ready);

    always_comb begin
        w_wide_re = EW'(r_sum_re) + EW'(w_term_re);
        w_wide_im = EW'(r_sum_im) + EW'(w_term_im);
        // out of range when the bits above the sign are not a copy of it
        w_ovf_re  = !((&w_wide_re[EW-1:ACC_WIDTH-1]) || (~|w_wide_re[EW-1:ACC_WIDTH-1]));
        w_ovf_im  = !((&w_wide_im[EW-1:ACC_WIDTH-1]) || (~|w_wide_im[EW-1:ACC_WIDTH-1]));
        n_sum_re  = clamp(w_wide_re, w_ovf_re);
        n_sum_im  = clamp(w_wide_im, w_ovf_im);
        n_sat     = r_sat || w_ovf_re || w_ovf_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_re    <= '0;
            r_sum_im    <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (w_last) begin
                    r_sum_re <= '0;
                    r_sum_im <= '0;
                    r_sat    <= 1'b0;
                end else begin
                    r_sum_re <= n_sum_re;
                    r_sum_im <= n_sum_im;
                    r_sat    <= n_sat;
                end
            end
            if (o_pop && w_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_last) begin
            r_dot_re <= n_sum_re;
            r_dot_im <= n_sum_im;
            r_ovf    <= n_sat;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.dot_real = r_dot_re;
    assign o_out.dot_imag = r_dot_im;
    assign o_out.overflow = r_ovf;

endmodule
